>>> src/lzss_window_decoder_unit_assert.svh
// Assertion macros used by the checker module of the window decoder.
// Depends on nothing; included by the checker file.
`ifndef LZSS_WINDOW_DECODER_UNIT_ASSERT_SVH
`define LZSS_WINDOW_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LZWD_ASSERT_NOW(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("lzwd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LZWD_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("lzwd assertion failed");

`endif

>>> src/lzwd_pkg.sv
// Constants and types of the LZSS window decoder.
// No dependencies; used by the top level and its checker.
package lzwd_pkg;

	localparam int WIN_AW    = 12;
	localparam int WIN_DEPTH = 1 << WIN_AW;
	localparam int BYTE_W    = 8;
	localparam int WORD_W    = 16;
	localparam int LEN_W     = WORD_W - WIN_AW;

	typedef logic [WIN_AW-1:0] idx_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [LEN_W-1:0]  len_t;
	// One bit wider than the length field, so it holds a full copy length minus one.
	typedef logic [LEN_W:0]    cnt_t;

	localparam idx_t IDX_RESET = idx_t'(1);
	localparam idx_t IDX_END   = idx_t'(0);

endpackage

>>> src/lzss_window_decoder_unit.sv
// LZSS window decoder top level: sequencer, 4096-byte history memory and output register.
// Depends on lzwd_pkg.
//
// Decodes one token at a time. After reset the history memory is cleared one entry per
// cycle, so no token is taken until the clearing pass is done. A literal token and an
// end-of-stream command go straight to the emit step; a copy command of n bytes (2 to
// 17) goes through a read step and an emit step for every byte: the registered read of
// the history memory, then the write back and the load of the output register. The output
// register lets a finished byte wait while the next one is fetched; a stalled output
// holds the sequencer in its emit step.
module lzss_window_decoder_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      func,
	input  logic [lzwd_pkg::BYTE_W-1:0] literal_byte,
	input  logic [lzwd_pkg::WORD_W-1:0] match_word,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [lzwd_pkg::BYTE_W-1:0] data_byte,
	output logic                      data_valid,
	output logic                      last,
	output logic                      stream_end
);

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	localparam logic [1:0] KIND_LIT  = 2'd0;
	localparam logic [1:0] KIND_COPY = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	logic [1:0]       state_q;
	logic [1:0]       kind_q;
	lzwd_pkg::idx_t   clr_idx_q;
	lzwd_pkg::idx_t   wr_idx_q;
	lzwd_pkg::idx_t   pos_q;
	lzwd_pkg::cnt_t   cnt_q;
	lzwd_pkg::byte_t  lit_q;
	lzwd_pkg::byte_t  rd_data_q;

	lzwd_pkg::byte_t  window_mem [lzwd_pkg::WIN_DEPTH];

	logic             out_valid_q;
	lzwd_pkg::byte_t  data_byte_q;
	logic             data_valid_q;
	logic             last_q;
	logic             end_q;

	logic             in_fire;
	logic             out_free;
	logic             emit_fire;
	logic             mem_we;
	lzwd_pkg::idx_t   mem_wa;
	lzwd_pkg::byte_t  mem_wd;
	lzwd_pkg::byte_t  emit_byte;
	lzwd_pkg::idx_t   in_pos;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign in_pos    = match_word[lzwd_pkg::WIN_AW-1:0];
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_fire = (state_q == ST_EMIT) && out_free;
	assign emit_byte = (kind_q == KIND_LIT) ? lit_q : rd_data_q;

	// One write port shared by the clearing pass and the decoded bytes.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = wr_idx_q;
		mem_wd = emit_byte;
		if (state_q == ST_CLR) begin
			mem_we = 1'b1;
			mem_wa = clr_idx_q;
			mem_wd = '0;
		end else if (emit_fire && (kind_q != KIND_END)) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			window_mem[mem_wa] <= mem_wd;
		end
		if (state_q == ST_RD) begin
			rd_data_q <= window_mem[pos_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_idx_q <= '0;
			wr_idx_q  <= lzwd_pkg::IDX_RESET;
			kind_q    <= KIND_LIT;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						if (func) begin
							kind_q  <= KIND_LIT;
							state_q <= ST_EMIT;
						end else if (in_pos == lzwd_pkg::IDX_END) begin
							kind_q  <= KIND_END;
							state_q <= ST_EMIT;
						end else begin
							kind_q  <= KIND_COPY;
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (kind_q == KIND_END) begin
							wr_idx_q <= lzwd_pkg::IDX_RESET;
							state_q  <= ST_IDLE;
						end else begin
							wr_idx_q <= wr_idx_q + 1'b1;
							if ((kind_q == KIND_COPY) && (cnt_q != '0)) begin
								state_q <= ST_RD;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Token payload: length counts the bytes still to copy after the current one.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			lit_q <= literal_byte;
			pos_q <= in_pos;
			cnt_q <= lzwd_pkg::cnt_t'(match_word[lzwd_pkg::WORD_W-1:lzwd_pkg::WIN_AW])
				+ lzwd_pkg::cnt_t'(1);
		end else if (emit_fire && (kind_q == KIND_COPY)) begin
			pos_q <= pos_q + 1'b1;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			data_byte_q  <= (kind_q == KIND_END) ? '0 : emit_byte;
			data_valid_q <= (kind_q != KIND_END);
			last_q       <= (kind_q != KIND_COPY) || (cnt_q == '0);
			end_q        <= (kind_q == KIND_END);
		end
	end

	assign out_valid  = out_valid_q;
	assign data_byte  = data_byte_q;
	assign data_valid = data_valid_q;
	assign last       = last_q;
	assign stream_end = end_q;

endmodule

>>> src/lzwd_checker.sv
// Port-level checker for the LZSS window decoder, bound to the top level.
// Depends on lzwd_pkg and lzss_window_decoder_unit_assert.svh.
`include "lzss_window_decoder_unit_assert.svh"

module lzwd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [lzwd_pkg::BYTE_W-1:0] data_byte,
	input logic                        data_valid,
	input logic                        last,
	input logic                        stream_end
);

	// A result that is still waiting must stay offered.
	`LZWD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// The end marker is a single result that carries no byte.
	`LZWD_ASSERT_NOW(a_end_shape, clk, arst_n, out_valid && stream_end,
		last && !data_valid && (data_byte == '0))

	// Only the end marker comes without a byte.
	`LZWD_ASSERT_NOW(a_novalid_is_end, clk, arst_n, out_valid && !data_valid, stream_end)

	// After a token transfer the block is busy with it in the following cycle.
	`LZWD_ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && !in_stall, in_stall)

endmodule

bind lzss_window_decoder_unit lzwd_checker u_lzwd_checker (.*);

>>> tb/lzss_window_decoder_unit_checker.sv
`timescale 1ns / 100ps
// Result checker for the LZSS window decoder: models the history window and write index,
// predicts the bytes of every accepted token and compares each output transfer in order.
// Depends on lzwd_pkg.
module lzss_window_decoder_unit_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        func,
	input  logic [lzwd_pkg::BYTE_W-1:0] literal_byte,
	input  logic [lzwd_pkg::WORD_W-1:0] match_word,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [lzwd_pkg::BYTE_W-1:0] data_byte,
	input  logic                        data_valid,
	input  logic                        last,
	input  logic                        stream_end,
	output int                          fail_count,
	output int                          results_pending
);

	typedef struct packed {
		lzwd_pkg::byte_t byte_val;
		logic            has_byte;
		logic            is_last;
		logic            is_end;
	} decoded_t;

	lzwd_pkg::byte_t history [lzwd_pkg::WIN_DEPTH];
	lzwd_pkg::idx_t  wr_idx;
	decoded_t        decoded_q [$];
	decoded_t        got;
	decoded_t        want;
	int              mismatches = 0;

	// Expands one token into the bytes it produces and updates the window copy.
	function automatic void decode_token(input logic kind, input lzwd_pkg::byte_t lit,
			input logic [lzwd_pkg::WORD_W-1:0] word);
		decoded_t       r;
		lzwd_pkg::idx_t src;
		int             count;
		src   = word[lzwd_pkg::WIN_AW-1:0];
		count = int'(word[lzwd_pkg::WORD_W-1:lzwd_pkg::WIN_AW]) + 2;
		if (kind) begin
			history[wr_idx] = lit;
			wr_idx = wr_idx + lzwd_pkg::idx_t'(1);
			r = '{byte_val: lit, has_byte: 1'b1, is_last: 1'b1, is_end: 1'b0};
			decoded_q.push_back(r);
		end else if (src == lzwd_pkg::IDX_END) begin
			// End of stream: the window is kept, only the index starts over.
			wr_idx = lzwd_pkg::IDX_RESET;
			r = '{byte_val: '0, has_byte: 1'b0, is_last: 1'b1, is_end: 1'b1};
			decoded_q.push_back(r);
		end else begin
			// Byte by byte, so an overlapping copy replays bytes it has just written.
			for (int k = 0; k < count; k++) begin
				r.byte_val = history[src];
				r.has_byte = 1'b1;
				r.is_last  = (k == count - 1);
				r.is_end   = 1'b0;
				history[wr_idx] = r.byte_val;
				wr_idx = wr_idx + lzwd_pkg::idx_t'(1);
				src    = src + lzwd_pkg::idx_t'(1);
				decoded_q.push_back(r);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lzwd_pkg::WIN_DEPTH; i++)
				history[i] = '0;
			wr_idx = lzwd_pkg::IDX_RESET;
			decoded_q.delete();
			fail_count      <= mismatches;
			results_pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				decode_token(func, literal_byte, match_word);
			if (out_valid && !out_stall) begin
				got = {data_byte, data_valid, last, stream_end};
				if (decoded_q.size() == 0) begin
					$display({"%0t: output transfer with nothing expected: ",
						"byte %02h valid %b last %b end %b"},
						$time, got.byte_val, got.has_byte, got.is_last, got.is_end);
					mismatches++;
				end else begin
					want = decoded_q.pop_front();
					if (got !== want) begin
						$display({"%0t: expected byte %02h valid %b last %b end %b, ",
							"actual byte %02h valid %b last %b end %b"},
							$time, want.byte_val, want.has_byte, want.is_last,
							want.is_end, got.byte_val, got.has_byte, got.is_last,
							got.is_end);
						mismatches++;
					end
				end
			end
			fail_count      <= mismatches;
			results_pending <= decoded_q.size();
		end
	end

endmodule

>>> tb/lzss_window_decoder_unit_test.sv
`timescale 1ns / 100ps
// Testbench top for the LZSS window decoder: clock, reset, token stimulus and output stalls.
// Depends on lzwd_pkg, lzss_window_decoder_unit and lzss_window_decoder_unit_checker.
module lzss_window_decoder_unit_test;

	localparam int HOLD_OFF_CYCLES = 400;

	typedef logic [lzwd_pkg::WORD_W-1:0] word_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic               func         = 1'b0;
	lzwd_pkg::byte_t    literal_byte = '0;
	word_t              match_word   = '0;
	logic               out_valid;
	logic               out_stall    = 1'b0;
	lzwd_pkg::byte_t    data_byte;
	logic               data_valid;
	logic               last;
	logic               stream_end;
	int                 fail_count;
	int                 results_pending;

	int   send_idle_pct     = 0;
	int   recv_stall_pct    = 0;
	int   hold_off_requests = 0;
	int   hold_off_served   = 0;
	int   hold_left         = 0;
	// Write index as the feeder sees it, used to aim copies close behind it.
	lzwd_pkg::idx_t feed_index = lzwd_pkg::IDX_RESET;

	lzss_window_decoder_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.literal_byte (literal_byte),
		.match_word   (match_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_byte    (data_byte),
		.data_valid   (data_valid),
		.last         (last),
		.stream_end   (stream_end)
	);

	lzss_window_decoder_unit_checker result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.literal_byte    (literal_byte),
		.match_word      (match_word),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.data_byte       (data_byte),
		.data_valid      (data_valid),
		.last            (last),
		.stream_end      (stream_end),
		.fail_count      (fail_count),
		.results_pending (results_pending)
	);

	always #2 clk = ~clk;

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_token(input logic kind, input lzwd_pkg::byte_t lit, input word_t word);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		func         <= kind;
		literal_byte <= lit;
		match_word   <= word;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		if (kind)
			feed_index = feed_index + lzwd_pkg::idx_t'(1);
		else if (word[lzwd_pkg::WIN_AW-1:0] == lzwd_pkg::IDX_END)
			feed_index = lzwd_pkg::IDX_RESET;
		else
			feed_index = feed_index + lzwd_pkg::idx_t'(word[lzwd_pkg::WORD_W-1:lzwd_pkg::WIN_AW])
				+ lzwd_pkg::idx_t'(2);
	endtask

	task automatic random_token(input int lit_pct, input int end_pct, input bit long_only);
		int             roll;
		lzwd_pkg::len_t len;
		lzwd_pkg::idx_t pos;
		roll = $urandom_range(99);
		if (roll < lit_pct) begin
			send_token(1'b1, lzwd_pkg::byte_t'($urandom_range(255)),
				word_t'($urandom_range(65535)));
		end else if (roll < lit_pct + end_pct) begin
			send_token(1'b0, lzwd_pkg::byte_t'($urandom_range(255)),
				{lzwd_pkg::len_t'($urandom_range(15)), lzwd_pkg::IDX_END});
		end else begin
			if (long_only || $urandom_range(1) == 1)
				len = '1;
			else
				len = lzwd_pkg::len_t'($urandom_range(15));
			// A quarter of the copies start just behind the write index or on it.
			if ($urandom_range(3) == 0)
				pos = feed_index - lzwd_pkg::idx_t'($urandom_range(17));
			else
				pos = lzwd_pkg::idx_t'($urandom_range(lzwd_pkg::WIN_DEPTH - 1, 1));
			if (pos == lzwd_pkg::IDX_END)
				pos = '1;
			send_token(1'b0, lzwd_pkg::byte_t'($urandom_range(255)), {len, pos});
		end
	endtask

	// Output stall driver, including the long hold-off that backs the block up.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_served != hold_off_requests) begin
				hold_off_served++;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	initial begin
		lzwd_pkg::idx_t prev_index;
		bit             wrapped;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed tokens: literal extremes, then copies (some aimed at the index) and end markers.
		send_token(1'b1, 8'h00, 16'hFFFF);
		send_token(1'b1, 8'hFF, 16'h0000);
		send_token(1'b1, 8'hA5, 16'h1234);
		send_token(1'b1, 8'h5A, 16'hEDCB);
		send_token(1'b0, 8'h00, {4'h0, lzwd_pkg::idx_t'(1)});
		send_token(1'b0, 8'hFF, {4'hF, lzwd_pkg::idx_t'(2)});
		// Self reference: the copy starts on the write index itself.
		send_token(1'b0, 8'h00, {4'h3, feed_index});
		// Starts on an entry never written and wraps from the top of the window to its bottom.
		send_token(1'b0, 8'h3C, {4'h2, lzwd_pkg::idx_t'(lzwd_pkg::WIN_DEPTH - 1)});
		// Distance one: the same byte is replayed seventeen times.
		send_token(1'b0, 8'hC3, {4'hF, feed_index - lzwd_pkg::idx_t'(1)});
		send_token(1'b1, 8'h81, 16'h0000);
		send_token(1'b0, 8'hFF, {4'h1, lzwd_pkg::idx_t'(3)});
		send_token(1'b0, 8'h00, {4'h0, lzwd_pkg::IDX_END});
		send_token(1'b0, 8'hFF, {4'hF, lzwd_pkg::IDX_END});
		send_token(1'b1, 8'h7E, 16'hFFFF);
		send_token(1'b0, 8'h18, {4'h6, lzwd_pkg::idx_t'(lzwd_pkg::WIN_DEPTH / 2)});
		send_token(1'b0, 8'hE7, {4'h1, lzwd_pkg::idx_t'(lzwd_pkg::WIN_DEPTH / 2 - 1)});
		send_token(1'b0, 8'h42, {4'h5, lzwd_pkg::IDX_END});

		// Long copies until the write index wraps past the top of the window.
		wrapped = 1'b0;
		while (!wrapped) begin
			prev_index = feed_index;
			random_token(0, 0, 1'b1);
			wrapped = (feed_index < prev_index);
		end

		send_idle_pct  = 67;
		recv_stall_pct = 0;
		repeat (6) random_token(25, 4, 1'b0);
		send_idle_pct  = 0;
		recv_stall_pct = 67;
		repeat (6) random_token(25, 4, 1'b0);
		send_idle_pct  = 14;
		recv_stall_pct = 14;
		repeat (6) random_token(25, 4, 1'b0);

		// The receiver holds off while tokens keep coming, so the input stalls.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_off_requests++;
		repeat (6) random_token(20, 3, 1'b0);

		in_valid <= 1'b0;
		while (results_pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("lzss_window_decoder_unit: match");
		else
			$display("lzss_window_decoder_unit: mismatch");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("lzss_window_decoder_unit: mismatch");
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/lzwd_pkg.sv
src/lzss_window_decoder_unit.sv
src/lzwd_checker.sv
tb/lzss_window_decoder_unit_checker.sv
tb/lzss_window_decoder_unit_test.sv
